// File: hdl/jerk_limited_velocity_slew_limiter_assert.svh
// Assertion macros for the jerk-limited velocity slew limiter.
// All macros sample on clk and are disabled while rst_n is low.
`ifndef JERK_LIMITED_VELOCITY_SLEW_LIMITER_ASSERT_SVH
`define JERK_LIMITED_VELOCITY_SLEW_LIMITER_ASSERT_SVH

// Checks that the consequent holds in the next cycle.
`define JLVSL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the same cycle.
`define JLVSL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: hdl/jlvsl_pkg.sv
// ----------------------------------------------------------------------------
// jlvsl_pkg
// Shared types and constants for the jerk-limited velocity slew limiter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package jlvsl_pkg;

    localparam int unsigned AccelW  = 31;
    localparam int unsigned VelW    = 32;
    localparam int unsigned StickW  = 16;
    localparam int unsigned PeriodW = 24;
    localparam int unsigned ProdW   = AccelW + PeriodW;
    localparam int unsigned AddrW   = 4;
    localparam int unsigned DataW   = 32;

    localparam logic [AccelW-1:0] AccelUpReset   = 31'd262144;
    localparam logic [AccelW-1:0] AccelDownReset = 31'd196608;
    localparam logic [AccelW-1:0] JerkReset      = 31'd1310720;

    // register indexes (paddr[3:2])
    localparam logic [1:0] RegAccelUp   = 2'd0;
    localparam logic [1:0] RegAccelDown = 2'd1;
    localparam logic [1:0] RegJerk      = 2'd2;

    typedef struct packed {
        logic signed [VelW-1:0]   velocity_request;
        logic signed [StickW-1:0] stick_deflection;
        logic signed [VelW-1:0]   measured_velocity;
        logic [PeriodW-1:0]       tick_period;
    } in_t;

    typedef struct packed {
        logic signed [VelW-1:0] velocity_limited;
        logic                   braking;
        logic [AccelW-1:0]      accel_limit_now;
    } out_t;

    typedef struct packed {
        logic [AccelW-1:0] accel_up_max;
        logic [AccelW-1:0] accel_down_max;
        logic [AccelW-1:0] jerk_limit;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic prep;
        logic limit;
        logic mul_slew;
        logic slew;
    } cmd_t;

    typedef struct packed {
        logic out_busy;
    } status_t;

endpackage

// File: hdl/jerk_limited_velocity_slew_limiter.sv
// Steps from input acceptance to out_valid: product, limit, product, slew.
// Input is taken only after the slew step; the single shared 31x24 multiplier is used twice.
// A waiting result holds the slew step only; no new transaction is accepted meanwhile.
// Reset: async active low; limits return to 4.0/3.0/20.0, setpoint, limit and brake flag clear.
// ----------------------------------------------------------------------------
// jerk_limited_velocity_slew_limiter
// Vertical velocity setpoint slew limiter with jerk-limited braking ramp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "jerk_limited_velocity_slew_limiter_assert.svh"

module jerk_limited_velocity_slew_limiter (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [jlvsl_pkg::AddrW-1:0] paddr,
    input  logic [jlvsl_pkg::DataW-1:0] pwdata,
    output logic [jlvsl_pkg::DataW-1:0] prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  jlvsl_pkg::in_t              in_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output jlvsl_pkg::out_t             out_data
);

    jlvsl_pkg::cfg_t    cfg;
    jlvsl_pkg::cmd_t    cmd;
    jlvsl_pkg::status_t status;

    jlvsl_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    jlvsl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    jlvsl_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd       (cmd),
        .status    (status),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    `JLVSL_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted while busy")
    `JLVSL_ASSERT_NEXT(a_out_drains, out_valid && !out_stall && !cmd.slew,
        !out_valid, "result repeated")
    `JLVSL_ASSERT_NOW(a_cmd_onehot, 1'b1, $onehot0(cmd), "overlapping commands")
    `JLVSL_ASSERT_NOW(a_brake_limit, out_valid && out_data.braking,
        out_data.accel_limit_now <= cfg.accel_up_max, "brake limit overshoot")

endmodule

// File: hdl/jlvsl_cfg.sv
// ----------------------------------------------------------------------------
// jlvsl_cfg
// APB register file holding the acceleration and jerk limits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jlvsl_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [jlvsl_pkg::AddrW-1:0] paddr,
    input  logic [jlvsl_pkg::DataW-1:0] pwdata,
    output logic [jlvsl_pkg::DataW-1:0] prdata,
    output logic                        pready,
    output jlvsl_pkg::cfg_t             cfg
);

    jlvsl_pkg::cfg_t cfg_reg;
    jlvsl_pkg::cfg_t cfg_next;
    logic            wr_en;
    logic [1:0]      reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                jlvsl_pkg::RegAccelUp:   cfg_next.accel_up_max   = pwdata[30:0];
                jlvsl_pkg::RegAccelDown: cfg_next.accel_down_max = pwdata[30:0];
                jlvsl_pkg::RegJerk:      cfg_next.jerk_limit     = pwdata[30:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            jlvsl_pkg::RegAccelUp:   prdata = {1'b0, cfg_reg.accel_up_max};
            jlvsl_pkg::RegAccelDown: prdata = {1'b0, cfg_reg.accel_down_max};
            jlvsl_pkg::RegJerk:      prdata = {1'b0, cfg_reg.jerk_limit};
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.accel_up_max   <= jlvsl_pkg::AccelUpReset;
            cfg_reg.accel_down_max <= jlvsl_pkg::AccelDownReset;
            cfg_reg.jerk_limit     <= jlvsl_pkg::JerkReset;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: hdl/jlvsl_ctrl.sv
// ----------------------------------------------------------------------------
// jlvsl_ctrl
// Sequencer: load, first product, limit update, slew product, slew result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jlvsl_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  jlvsl_pkg::status_t   status,
    output jlvsl_pkg::cmd_t      cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_PREP  = 5'b00010,
        S_LIMIT = 5'b00100,
        S_MUL   = 5'b01000,
        S_SLEW  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = S_LIMIT;
            end
            S_LIMIT:
            begin
                cmd.limit  = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_slew = 1'b1;
                state_next   = S_SLEW;
            end
            S_SLEW:
            begin
                if (!status.out_busy)
                begin
                    cmd.slew   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: hdl/jlvsl_dp.sv
// ----------------------------------------------------------------------------
// jlvsl_dp
// Datapath: one shared 31x24 multiplier, limit update, slew clamp, output reg.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jlvsl_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  jlvsl_pkg::cfg_t      cfg,
    input  jlvsl_pkg::cmd_t      cmd,
    output jlvsl_pkg::status_t   status,
    input  jlvsl_pkg::in_t       in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output jlvsl_pkg::out_t      out_data
);

    localparam int unsigned AW = jlvsl_pkg::AccelW;
    localparam int unsigned PW = jlvsl_pkg::ProdW;

    jlvsl_pkg::in_t         in_reg;
    logic signed [31:0]     prev_reg;
    logic signed [31:0]     prev_next;
    logic [AW-1:0]          limit_reg;
    logic [AW-1:0]          limit_next;
    logic                   brake_mode_reg;
    logic                   brake_mode_next;
    logic [PW-1:0]          prod_reg;
    jlvsl_pkg::out_t        out_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;

    logic                   brake;
    logic                   stick_neg;
    logic [15:0]            mag_s;
    logic signed [31:0]     d_up;
    logic                   d_neg;
    logic [AW-1:0]          mag_d;
    logic [AW-1:0]          mul_a;
    logic [23:0]            mul_b;
    logic [PW-1:0]          product;
    logic [PW-1:0]          rnd24;
    logic [AW-1:0]          step24;
    logic [45:0]            rnd15;
    logic [AW-1:0]          r15;
    logic signed [31:0]     gap;
    logic                   gap_pos;
    logic                   gap_over;
    logic [AW-1:0]          interp;
    logic signed [32:0]     diff;
    logic [31:0]            mag;
    logic                   clamp;
    logic signed [33:0]     stepped;
    logic signed [31:0]     res;

    assign brake     = (in_reg.stick_deflection == '0);
    assign stick_neg = in_reg.stick_deflection[15];
    assign mag_s     = stick_neg ? 16'(-in_reg.stick_deflection)
                                 : 16'(in_reg.stick_deflection);

    assign d_up  = $signed({1'b0, cfg.accel_up_max}) - $signed({1'b0, cfg.accel_down_max});
    assign d_neg = stick_neg && d_up[31];
    assign mag_d = !stick_neg ? '0 : (d_up[31] ? AW'(-d_up) : d_up[AW-1:0]);

    always_comb
    begin
        if (cmd.prep && brake)
        begin
            mul_a = cfg.jerk_limit;
            mul_b = in_reg.tick_period;
        end
        else if (cmd.prep)
        begin
            mul_a = mag_d;
            mul_b = {8'b0, mag_s};
        end
        else
        begin
            mul_a = limit_reg;
            mul_b = in_reg.tick_period;
        end
    end

    assign product = {24'b0, mul_a} * {31'b0, mul_b};

    // rounding of the registered product
    assign rnd24  = prod_reg + {31'b0, 1'b1, 23'b0};
    assign step24 = rnd24[PW-1:24];
    assign rnd15  = prod_reg[45:0] + {31'b0, 1'b1, 14'b0};
    assign r15    = rnd15[45:15];

    assign gap      = $signed({1'b0, cfg.accel_up_max}) - $signed({1'b0, limit_reg});
    assign gap_pos  = !gap[31] && (gap != '0);
    assign gap_over = {gap[AW-1:0], 24'b0} > prod_reg;
    assign interp   = d_neg ? AW'(cfg.accel_down_max - r15) : AW'(cfg.accel_down_max + r15);

    // slew clamp
    assign diff    = {in_reg.velocity_request[31], in_reg.velocity_request}
                   - {prev_reg[31], prev_reg};
    assign mag     = diff[32] ? 32'(-diff) : diff[31:0];
    assign clamp   = {mag, 24'b0} > {1'b0, prod_reg};
    assign stepped = diff[32] ? ({{2{prev_reg[31]}}, prev_reg} - {3'b0, step24})
                              : ({{2{prev_reg[31]}}, prev_reg} + {3'b0, step24});

    always_comb
    begin
        if (!clamp)
        begin
            res = in_reg.velocity_request;
        end
        else if (stepped > 34'sh0_7FFF_FFFF)
        begin
            res = 32'sh7FFF_FFFF;
        end
        else if (stepped < -34'sh0_8000_0000)
        begin
            res = -32'sh8000_0000;
        end
        else
        begin
            res = stepped[31:0];
        end
    end

    always_comb
    begin
        prev_next       = prev_reg;
        limit_next      = limit_reg;
        brake_mode_next = brake_mode_reg;
        if (cmd.prep && brake && !brake_mode_reg)
        begin
            limit_next = cfg.accel_down_max;
            prev_next  = in_reg.measured_velocity;
        end
        if (cmd.limit)
        begin
            brake_mode_next = brake;
            if (!brake)
            begin
                limit_next = interp;
            end
            else if (gap_pos && gap_over)
            begin
                limit_next = AW'(limit_reg + step24);
            end
            else
            begin
                limit_next = cfg.accel_up_max;
            end
        end
        if (cmd.slew)
        begin
            prev_next = res;
        end
    end

    assign out_valid_next = cmd.slew || (out_valid_reg && out_stall);
    assign status.out_busy = out_valid_reg && out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg       <= '0;
            limit_reg      <= '0;
            brake_mode_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            prev_reg       <= prev_next;
            limit_reg      <= limit_next;
            brake_mode_reg <= brake_mode_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            in_reg <= in_data;
        end
        if (cmd.prep || cmd.mul_slew)
        begin
            prod_reg <= product;
        end
        if (cmd.slew)
        begin
            out_reg.velocity_limited <= res;
            out_reg.braking          <= brake_mode_reg;
            out_reg.accel_limit_now  <= limit_reg;
        end
    end

endmodule

// File: tb/sv/tb_jerk_limited_velocity_slew_limiter.sv
// ----------------------------------------------------------------------------
// tb_jerk_limited_velocity_slew_limiter
// Self-checking bench for the jerk-limited vertical velocity slew limiter.
// A short directed sequence is followed by random tick bursts (braking runs and
// stick deflection runs) under several acceleration and jerk limit settings
// written over APB. A scoreboard predicts each output transaction and checks
// every field. Both handshake sides insert random gaps and stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_jerk_limited_velocity_slew_limiter;

    localparam longint HalfQ24 = 64'sd1 << 23;
    localparam longint HalfQ15 = 64'sd1 << 14;
    localparam longint VelMax  = 64'sd2147483647;
    localparam longint VelMin  = -64'sd2147483648;

    class slew_scoreboard;
        bit [jlvsl_pkg::AccelW-1:0] up_max;
        bit [jlvsl_pkg::AccelW-1:0] down_max;
        bit [jlvsl_pkg::AccelW-1:0] jerk_max;
        bit signed [31:0]           setpoint;
        bit                         brake_held;
        bit [31:0]                  limit_now;
        jlvsl_pkg::out_t            setpoint_q[$];
        int unsigned                failures;

        function new();
            up_max     = jlvsl_pkg::AccelUpReset;
            down_max   = jlvsl_pkg::AccelDownReset;
            jerk_max   = jlvsl_pkg::JerkReset;
            setpoint   = '0;
            brake_held = 1'b0;
            limit_now  = '0;
            failures   = 0;
        endfunction

        function void set_limit(logic [1:0] idx, logic [31:0] val);
            case (idx)
                jlvsl_pkg::RegAccelUp:   up_max   = val[jlvsl_pkg::AccelW-1:0];
                jlvsl_pkg::RegAccelDown: down_max = val[jlvsl_pkg::AccelW-1:0];
                jlvsl_pkg::RegJerk:      jerk_max = val[jlvsl_pkg::AccelW-1:0];
                default: ;
            endcase
        endfunction

        function void take_request(jlvsl_pkg::in_t t);
            longint          req, stk, meas, dt, up, down, gap, jp, amax, mag_s, d, mag_d, r;
            longint          sp, diff, mag, lp, res;
            bit              brk;
            jlvsl_pkg::out_t want;
            req  = longint'(t.velocity_request);
            stk  = longint'(t.stick_deflection);
            meas = longint'(t.measured_velocity);
            dt   = longint'(t.tick_period);
            up   = longint'(up_max);
            down = longint'(down_max);
            brk  = (stk == 0);

            // entering brake: limit drops, setpoint snaps to measurement
            if (brk && !brake_held)
            begin
                limit_now = 32'(down_max);
                setpoint  = meas[31:0];
            end

            if (brk)
            begin
                gap = up - longint'(limit_now);
                jp  = longint'(jerk_max) * dt;
                if (gap > 0 && (gap << 24) > jp)
                    limit_now = limit_now + 32'((jp + HalfQ24) >> 24);
                else
                    limit_now = 32'(up_max);
            end
            else
            begin
                amax  = (stk < 0) ? up : down;
                mag_s = (stk < 0) ? -stk : stk;
                d     = amax - down;
                mag_d = (d < 0) ? -d : d;
                r     = (mag_d * mag_s + HalfQ15) >> 15;
                res   = (d < 0) ? down - r : down + r;
                limit_now = res[31:0];
            end
            brake_held = brk;

            sp   = longint'(setpoint);
            diff = req - sp;
            mag  = (diff < 0) ? -diff : diff;
            lp   = longint'(limit_now) * dt;
            res  = req;
            if ((mag << 24) > lp)
                res = (diff < 0) ? sp - ((lp + HalfQ24) >> 24) : sp + ((lp + HalfQ24) >> 24);
            if (res > VelMax)
                res = VelMax;
            else if (res < VelMin)
                res = VelMin;
            setpoint = res[31:0];

            want.velocity_limited = setpoint;
            want.braking          = brake_held;
            want.accel_limit_now  = limit_now[jlvsl_pkg::AccelW-1:0];
            setpoint_q.push_back(want);
        endfunction

        function void check_setpoint(jlvsl_pkg::out_t got);
            jlvsl_pkg::out_t want;
            if (setpoint_q.size() == 0)
            begin
                $error("unexpected transaction: velocity_limited %0d",
                    got.velocity_limited);
                failures++;
                return;
            end
            want = setpoint_q.pop_front();
            if (got.velocity_limited !== want.velocity_limited)
            begin
                $error("velocity_limited: expected %0d, got %0d",
                    want.velocity_limited, got.velocity_limited);
                failures++;
            end
            if (got.braking !== want.braking)
            begin
                $error("braking: expected %0b, got %0b", want.braking, got.braking);
                failures++;
            end
            if (got.accel_limit_now !== want.accel_limit_now)
            begin
                $error("accel_limit_now: expected %0d, got %0d",
                    want.accel_limit_now, got.accel_limit_now);
                failures++;
            end
        endfunction
    endclass

    logic                        clk       = 1'b0;
    logic                        rst_n     = 1'b0;
    logic                        psel      = 1'b0;
    logic                        penable   = 1'b0;
    logic                        pwrite    = 1'b0;
    logic [jlvsl_pkg::AddrW-1:0] paddr     = '0;
    logic [jlvsl_pkg::DataW-1:0] pwdata    = '0;
    logic [jlvsl_pkg::DataW-1:0] prdata;
    logic                        pready;
    logic                        in_valid  = 1'b0;
    logic                        in_stall;
    jlvsl_pkg::in_t              in_data   = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    jlvsl_pkg::out_t             out_data;

    slew_scoreboard    sb = new();
    bit                quiet = 1'b0;
    int                stall_left = 0;

    jerk_limited_velocity_slew_limiter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // the timeout lies well beyond the worst case, even with long gaps and stalls
    initial
    begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic int idle_len();
        int roll;
        if (quiet)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_setpoint(out_data);
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
            stall_left = idle_len();
        end
    end

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_limit(idx, val);
    endtask

    task automatic send_tick(jlvsl_pkg::in_t t);
        int gap;
        gap = idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.take_request(t);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.setpoint_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic jlvsl_pkg::in_t make_tick(logic [31:0] req, logic [15:0] stk,
                                                 logic [31:0] meas, logic [23:0] dt);
        jlvsl_pkg::in_t t;
        t.velocity_request  = req;
        t.stick_deflection  = stk;
        t.measured_velocity = meas;
        t.tick_period       = dt;
        return t;
    endfunction

    function automatic jlvsl_pkg::in_t rand_tick(bit brk);
        logic [31:0] req, meas;
        logic [15:0] stk;
        logic [23:0] dt;
        int          roll;
        meas = $urandom_range(0, 1) ? $urandom : ($signed($urandom) >>> 9);
        roll = $urandom_range(0, 99);
        if (roll < 40)
            req = meas + ($signed($urandom) >>> 14);
        else if (roll < 70)
            req = $signed($urandom) >>> 6;
        else
            req = $urandom;
        roll = $urandom_range(0, 99);
        if (brk)
            stk = '0;
        else if (roll < 10)
            stk = 16'h8000;
        else if (roll < 15)
            stk = 16'h7FFF;
        else if (roll < 20)
            stk = $urandom_range(0, 1) ? 16'h0001 : 16'hFFFF;
        else
            stk = 16'($urandom_range(1, 65535));
        roll = $urandom_range(0, 99);
        if (roll < 8)
            dt = '0;
        else if (roll < 13)
            dt = 24'hFFFFFF;
        else if (roll < 25)
            dt = 24'($urandom);
        else
            dt = 24'($urandom_range(1, 1 << 18));
        return make_tick(req, stk, meas, dt);
    endfunction

    task automatic program_phase(int p);
        case (p)
            0:
            begin
                reg_write(jlvsl_pkg::RegAccelUp, 32'hFFFF_FFFF);
                reg_write(jlvsl_pkg::RegAccelDown, 32'h7FFF_FFFF);
                reg_write(jlvsl_pkg::RegJerk, 32'hFFFF_FFFF);
            end
            1:
            begin
                reg_write(jlvsl_pkg::RegAccelUp, '0);
                reg_write(jlvsl_pkg::RegAccelDown, '0);
                reg_write(jlvsl_pkg::RegJerk, '0);
            end
            2:
            begin
                // down above up: braking limit clamps to up at once
                reg_write(jlvsl_pkg::RegAccelUp, 32'd1 << 16);
                reg_write(jlvsl_pkg::RegAccelDown, 32'd5 << 16);
                reg_write(jlvsl_pkg::RegJerk, 32'd30 << 16);
            end
            3:
            begin
                reg_write(jlvsl_pkg::RegAccelUp,
                    {1'($urandom), 31'($urandom_range(0, 16 << 16))});
                reg_write(jlvsl_pkg::RegAccelDown,
                    {1'($urandom), 31'($urandom_range(0, 16 << 16))});
                reg_write(jlvsl_pkg::RegJerk,
                    {1'($urandom), 31'($urandom_range(0, 200 << 16))});
            end
            4:
            begin
                reg_write(jlvsl_pkg::RegAccelUp, $urandom);
                reg_write(jlvsl_pkg::RegAccelDown, $urandom);
                reg_write(jlvsl_pkg::RegJerk, $urandom);
            end
            default:
            begin
                reg_write(jlvsl_pkg::RegAccelUp, 32'(jlvsl_pkg::AccelUpReset));
                reg_write(jlvsl_pkg::RegAccelDown, 32'(jlvsl_pkg::AccelDownReset));
                reg_write(jlvsl_pkg::RegJerk, 32'(jlvsl_pkg::JerkReset));
            end
        endcase
    endtask

    initial
    begin
        int p, k, n, run;
        bit brk;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, brake entry and ramp, zero period, stick edges
        send_tick(make_tick(32'h7FFF_FFFF, 16'h8000, 32'h0, 24'hFFFFFF));
        send_tick(make_tick(32'h8000_0000, 16'h7FFF, 32'h7FFF_FFFF, 24'h000001));
        send_tick(make_tick(32'd12345, 16'h0, 32'h8000_0000, 24'hFFFFFF));
        send_tick(make_tick(32'h0, 16'h0, 32'h0, 24'hFFFFFF));
        send_tick(make_tick(32'd1000, 16'h0, 32'h1234_5678, 24'h0));
        send_tick(make_tick(32'h0001_0000, 16'hFFFF, 32'h0, 24'h010000));
        send_tick(make_tick(32'hFFFF_0000, 16'h0001, 32'h0, 24'h010000));
        send_tick(make_tick(32'h0005_0000, 16'h4000, 32'h0, 24'h0));
        send_tick(make_tick(32'hFFFB_0000, 16'hC000, 32'h0, 24'h100000));
        send_tick(make_tick(32'hFFFF_0000, 16'h0, 32'h0001_0000, 24'h004000));
        send_tick(make_tick(32'hFFFF_0000, 16'h0, 32'h0, 24'h004000));
        send_tick(make_tick(32'hFFFF_0000, 16'h0, 32'h0, 24'h004000));
        send_tick(make_tick(32'h0, 16'h0, 32'h0, 24'h0));
        send_tick(make_tick(32'h7FFF_FFFF, 16'h8000, 32'h8000_0000, 24'hFFFFFF));
        send_tick(make_tick(32'h8000_0000, 16'h8000, 32'h7FFF_FFFF, 24'hFFFFFF));
        send_tick(make_tick(32'h0, 16'h8000, 32'h0, 24'h0));

        for (p = 0; p < 6; p++)
        begin
            drain();
            program_phase(p);
            quiet = (p == 3);
            n = 0;
            while (n < 100)
            begin
                brk = ($urandom_range(0, 99) < 35);
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24)
                                                  : $urandom_range(1, 8);
                for (k = 0; k < run; k++)
                begin
                    send_tick(rand_tick(brk));
                    n++;
                end
            end
        end

        in_valid <= 1'b0;
        quiet = 1'b0;
        while (sb.setpoint_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
